// ----- rtl/trsm_pkg.sv -----
package trsm_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int COUNT_BITS     = 16;
  localparam int SUM_BITS       = SAMPLE_BITS + COUNT_BITS;
  localparam int THRESH_BITS    = 15;
  localparam int CMP_BITS       = ((SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS) + 2;
  localparam int AXES           = 3;
  localparam int AXIS_BITS      = 2;
  localparam int QUEUE_DEPTH    = 2;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int ITER_BITS      = $clog2(SAMPLE_BITS);

  localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(410);

  typedef enum logic [1:0] {
    LEVEL_ZERO  = 2'd0,
    LEVEL_PLUS  = 2'd1,
    LEVEL_MINUS = 2'd2
  } level_t;

  typedef enum logic [1:0] {
    BACK_IDLE,
    BACK_LOAD,
    BACK_DIV,
    BACK_EMIT
  } back_state_t;

  typedef struct packed {
    logic [AXES-1:0][1:0]          levels;
    logic                          mean_valid;
    logic                          gesture_end;
    logic [AXES-1:0][SUM_BITS-1:0] sums;
    logic [COUNT_BITS-1:0]         count;
  } job_t;

  function automatic level_t quantize(input logic [SAMPLE_BITS-1:0] s,
                                      input logic [THRESH_BITS-1:0] t);
    logic signed [CMP_BITS-1:0] sx;
    logic signed [CMP_BITS-1:0] tp;
    logic signed [CMP_BITS-1:0] tn;
    sx = CMP_BITS'($signed(s));
    tp = $signed({{(CMP_BITS-THRESH_BITS){1'b0}}, t});
    tn = -tp;
    if (sx > tp) begin
      return LEVEL_PLUS;
    end else if (sx < tn) begin
      return LEVEL_MINUS;
    end else begin
      return LEVEL_ZERO;
    end
  endfunction

endpackage

// ----- rtl/trsm_front.sv -----
module trsm_front (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  input  logic [trsm_pkg::THRESH_BITS-1:0]       cfg_data,
  input  logic                                   push,
  input  logic                                   full,
  input  logic                                   button_held,
  input  logic signed [trsm_pkg::SAMPLE_BITS-1:0] accel_x,
  input  logic signed [trsm_pkg::SAMPLE_BITS-1:0] accel_y,
  input  logic signed [trsm_pkg::SAMPLE_BITS-1:0] accel_z,
  output logic                                   job_push,
  output trsm_pkg::job_t                         job
);

  logic [trsm_pkg::THRESH_BITS-1:0]                          threshold;
  logic [trsm_pkg::AXES-1:0][1:0]                            prev;
  logic [trsm_pkg::AXES-1:0][trsm_pkg::SUM_BITS-1:0]         sums;
  logic [trsm_pkg::COUNT_BITS-1:0]                           count;
  logic                                                      active;

  logic [trsm_pkg::AXES-1:0][trsm_pkg::SAMPLE_BITS-1:0]      samples;
  logic [trsm_pkg::AXES-1:0][trsm_pkg::SUM_BITS-1:0]         samples_ext;
  logic [trsm_pkg::AXES-1:0][1:0]                            lv;
  logic                                                      changed;
  logic                                                      accept;
  logic                                                      count_max;

  assign samples[0] = accel_x;
  assign samples[1] = accel_y;
  assign samples[2] = accel_z;

  always_comb begin
    changed = 1'b0;
    for (int i = 0; i < trsm_pkg::AXES; i++) begin
      lv[i]          = trsm_pkg::quantize(samples[i], threshold);
      samples_ext[i] = trsm_pkg::SUM_BITS'($signed(samples[i]));
      if (lv[i] != prev[i]) begin
        changed = 1'b1;
      end
    end
  end

  assign accept    = push && !full;
  assign job_push  = accept && (button_held || active);
  assign count_max = &count;

  always_comb begin
    job.levels      = lv;
    job.mean_valid  = !button_held || changed;
    job.gesture_end = !button_held;
    job.sums        = sums;
    job.count       = count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= trsm_pkg::THRESH_RESET;
      prev      <= '0;
      sums      <= '0;
      count     <= trsm_pkg::COUNT_BITS'(1);
      active    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        threshold <= cfg_data;
      end
      if (job_push) begin
        if (!button_held) begin
          prev   <= '0;
          sums   <= '0;
          count  <= trsm_pkg::COUNT_BITS'(1);
          active <= 1'b0;
        end else begin
          if (changed) begin
            sums  <= samples_ext;
            count <= trsm_pkg::COUNT_BITS'(1);
          end else if (!count_max) begin
            for (int i = 0; i < trsm_pkg::AXES; i++) begin
              sums[i] <= sums[i] + samples_ext[i];
            end
            count <= count + trsm_pkg::COUNT_BITS'(1);
          end
          prev   <= lv;
          active <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/trsm_queue.sv -----
module trsm_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  trsm_pkg::job_t wr_data,
  input  logic           rd_en,
  output trsm_pkg::job_t rd_data,
  output logic           full,
  output logic           empty
);

  trsm_pkg::job_t                        entries [trsm_pkg::QUEUE_DEPTH];
  logic [trsm_pkg::QUEUE_PTR_BITS-1:0]   wr_ptr;
  logic [trsm_pkg::QUEUE_PTR_BITS-1:0]   rd_ptr;
  logic [trsm_pkg::QUEUE_PTR_BITS:0]     fill;
  logic                                  do_wr;
  logic                                  do_rd;

  assign full    = fill == (trsm_pkg::QUEUE_PTR_BITS+1)'(trsm_pkg::QUEUE_DEPTH);
  assign empty   = fill == '0;
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        fill <= fill + 1'b1;
      end else if (do_rd && !do_wr) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/trsm_back.sv -----
module trsm_back (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    job_empty,
  input  trsm_pkg::job_t                          job,
  output logic                                    job_take,
  input  logic                                    pop,
  output logic                                    empty,
  output logic [1:0]                              level_x,
  output logic [1:0]                              level_y,
  output logic [1:0]                              level_z,
  output logic                                    mean_valid,
  output logic signed [trsm_pkg::SAMPLE_BITS-1:0] mean_x,
  output logic signed [trsm_pkg::SAMPLE_BITS-1:0] mean_y,
  output logic signed [trsm_pkg::SAMPLE_BITS-1:0] mean_z,
  output logic                                    gesture_end
);

  localparam logic [trsm_pkg::ITER_BITS-1:0] LAST_STEP =
    trsm_pkg::ITER_BITS'(trsm_pkg::SAMPLE_BITS - 1);
  localparam logic [trsm_pkg::AXIS_BITS-1:0] LAST_AXIS =
    trsm_pkg::AXIS_BITS'(trsm_pkg::AXES - 1);

  trsm_pkg::back_state_t                                  state;
  trsm_pkg::back_state_t                                  state_next;

  trsm_pkg::job_t                                         cur;
  logic [trsm_pkg::AXIS_BITS-1:0]                         axis;
  logic [trsm_pkg::ITER_BITS-1:0]                         step;
  logic [trsm_pkg::COUNT_BITS-1:0]                        rem;
  logic [trsm_pkg::SAMPLE_BITS-1:0]                       quo;
  logic                                                   neg;
  logic [trsm_pkg::AXES-1:0][trsm_pkg::SAMPLE_BITS-1:0]   means;

  logic                                                   out_valid;
  logic [trsm_pkg::AXES-1:0][1:0]                         out_levels;
  logic [trsm_pkg::AXES-1:0][trsm_pkg::SAMPLE_BITS-1:0]   out_means;
  logic                                                   out_mean_valid;
  logic                                                   out_end;

  logic                                                   out_free;
  logic                                                   load_en;
  logic                                                   div_en;
  logic                                                   last_step;
  logic                                                   emit;

  logic [trsm_pkg::SUM_BITS-1:0]                          dividend;
  logic [trsm_pkg::SUM_BITS-1:0]                          mag;
  logic [trsm_pkg::COUNT_BITS:0]                          trial;
  logic [trsm_pkg::COUNT_BITS:0]                          diff;
  logic                                                   ge;
  logic [trsm_pkg::COUNT_BITS-1:0]                        rem_new;
  logic [trsm_pkg::SAMPLE_BITS-1:0]                       quo_new;
  logic [trsm_pkg::SAMPLE_BITS-1:0]                       mean_val;

  assign out_free = !out_valid || pop;

  always_comb begin
    state_next = state;
    case (state)
      trsm_pkg::BACK_IDLE: begin
        if (!job_empty) begin
          state_next = job.mean_valid ? trsm_pkg::BACK_LOAD : trsm_pkg::BACK_EMIT;
        end
      end
      trsm_pkg::BACK_LOAD: begin
        state_next = trsm_pkg::BACK_DIV;
      end
      trsm_pkg::BACK_DIV: begin
        if (step == LAST_STEP) begin
          state_next = (axis == LAST_AXIS) ? trsm_pkg::BACK_EMIT : trsm_pkg::BACK_LOAD;
        end
      end
      trsm_pkg::BACK_EMIT: begin
        if (out_free) begin
          state_next = trsm_pkg::BACK_IDLE;
        end
      end
      default: begin
        state_next = trsm_pkg::BACK_IDLE;
      end
    endcase
  end

  always_comb begin
    job_take  = 1'b0;
    load_en   = 1'b0;
    div_en    = 1'b0;
    last_step = 1'b0;
    emit      = 1'b0;
    case (state)
      trsm_pkg::BACK_IDLE: begin
        job_take = !job_empty;
      end
      trsm_pkg::BACK_LOAD: begin
        load_en = 1'b1;
      end
      trsm_pkg::BACK_DIV: begin
        div_en    = 1'b1;
        last_step = step == LAST_STEP;
      end
      trsm_pkg::BACK_EMIT: begin
        emit = out_free;
      end
      default: begin
        job_take = 1'b0;
      end
    endcase
  end

  always_comb begin
    dividend = cur.sums[axis];
    mag      = dividend[trsm_pkg::SUM_BITS-1] ? -dividend : dividend;
    trial    = {rem, quo[trsm_pkg::SAMPLE_BITS-1]};
    diff     = trial - {1'b0, cur.count};
    ge       = trial >= {1'b0, cur.count};
    rem_new  = ge ? diff[trsm_pkg::COUNT_BITS-1:0] : trial[trsm_pkg::COUNT_BITS-1:0];
    quo_new  = {quo[trsm_pkg::SAMPLE_BITS-2:0], ge};
    mean_val = neg ? -quo_new : quo_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= trsm_pkg::BACK_IDLE;
      out_valid <= 1'b0;
      axis      <= '0;
      step      <= '0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (job_take) begin
        axis <= '0;
      end else if (last_step) begin
        axis <= axis + 1'b1;
      end
      if (load_en) begin
        step <= '0;
      end else if (div_en) begin
        step <= step + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      cur   <= job;
      means <= '0;
    end
    if (load_en) begin
      neg <= dividend[trsm_pkg::SUM_BITS-1];
      rem <= mag[trsm_pkg::SUM_BITS-1:trsm_pkg::SAMPLE_BITS];
      quo <= mag[trsm_pkg::SAMPLE_BITS-1:0];
    end
    if (div_en) begin
      rem <= rem_new;
      quo <= quo_new;
    end
    if (last_step) begin
      means[axis] <= mean_val;
    end
    if (emit) begin
      out_levels     <= cur.levels;
      out_means      <= means;
      out_mean_valid <= cur.mean_valid;
      out_end        <= cur.gesture_end;
    end
  end

  assign empty       = !out_valid;
  assign level_x     = out_levels[0];
  assign level_y     = out_levels[1];
  assign level_z     = out_levels[2];
  assign mean_x      = out_means[0];
  assign mean_y      = out_means[1];
  assign mean_z      = out_means[2];
  assign mean_valid  = out_mean_valid;
  assign gesture_end = out_end;

endmodule

// ----- rtl/tri_axis_run_segment_mean.sv -----
// Run-segment mean of a three-axis accelerometer stream. Each beat quantizes
// x, y and z against the threshold and, while the button is held, extends or
// closes a run of equal levels; a closing beat or a release yields the run's
// per-axis mean, truncated toward zero. The front takes one input beat per
// cycle, while full is low, into a two-entry job queue; the back runs one
// shared restoring divider, one quotient bit per cycle, over the three axes
// in turn and takes no new job until the last result has been emitted. The
// sustained rate of results with means is set by that divider; push sees
// full only while both queue entries wait on a busy or stalled back end.
module tri_axis_run_segment_mean (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [trsm_pkg::THRESH_BITS-1:0]        cfg_data,
  input  logic                                    push,
  output logic                                    full,
  input  logic                                    button_held,
  input  logic signed [trsm_pkg::SAMPLE_BITS-1:0] accel_x,
  input  logic signed [trsm_pkg::SAMPLE_BITS-1:0] accel_y,
  input  logic signed [trsm_pkg::SAMPLE_BITS-1:0] accel_z,
  output logic                                    empty,
  input  logic                                    pop,
  output logic [1:0]                              level_x,
  output logic [1:0]                              level_y,
  output logic [1:0]                              level_z,
  output logic                                    mean_valid,
  output logic signed [trsm_pkg::SAMPLE_BITS-1:0] mean_x,
  output logic signed [trsm_pkg::SAMPLE_BITS-1:0] mean_y,
  output logic signed [trsm_pkg::SAMPLE_BITS-1:0] mean_z,
  output logic                                    gesture_end
);

  trsm_pkg::job_t job_in;
  trsm_pkg::job_t job_out;
  logic           job_push;
  logic           job_take;
  logic           job_empty;

  assign cfg_ready = 1'b1;

  trsm_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .push        (push),
    .full        (full),
    .button_held (button_held),
    .accel_x     (accel_x),
    .accel_y     (accel_y),
    .accel_z     (accel_z),
    .job_push    (job_push),
    .job         (job_in)
  );

  trsm_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_push),
    .wr_data (job_in),
    .rd_en   (job_take),
    .rd_data (job_out),
    .full    (full),
    .empty   (job_empty)
  );

  trsm_back u_back (
    .clk         (clk),
    .rst         (rst),
    .job_empty   (job_empty),
    .job         (job_out),
    .job_take    (job_take),
    .pop         (pop),
    .empty       (empty),
    .level_x     (level_x),
    .level_y     (level_y),
    .level_z     (level_z),
    .mean_valid  (mean_valid),
    .mean_x      (mean_x),
    .mean_y      (mean_y),
    .mean_z      (mean_z),
    .gesture_end (gesture_end)
  );

endmodule

// ----- rtl/trsm_checker.sv -----
module trsm_checker (
  input logic                                    clk,
  input logic                                    rst,
  input logic                                    empty,
  input logic                                    pop,
  input logic [1:0]                              level_x,
  input logic [1:0]                              level_y,
  input logic [1:0]                              level_z,
  input logic                                    mean_valid,
  input logic signed [trsm_pkg::SAMPLE_BITS-1:0] mean_x,
  input logic signed [trsm_pkg::SAMPLE_BITS-1:0] mean_y,
  input logic signed [trsm_pkg::SAMPLE_BITS-1:0] mean_z,
  input logic                                    gesture_end
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(mean_x) && $stable(gesture_end)))
    else $error("waiting result dropped or changed");

  a_end_has_mean: assert property (@(posedge clk) disable iff (rst)
    (!empty && gesture_end) |-> mean_valid)
    else $error("gesture end without a mean");

  a_no_mean_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !mean_valid) |-> (mean_x == '0 && mean_y == '0 && mean_z == '0))
    else $error("mean fields set without a mean");

  a_level_code: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (level_x != 2'd3 && level_y != 2'd3 && level_z != 2'd3))
    else $error("level code out of range");

endmodule

bind tri_axis_run_segment_mean trsm_checker u_trsm_checker (.*);
